### sv/cartridge_bank_mapper_with_chr_split_macros.svh
// Assertion macros for the cartridge bank mapper checker.
// No dependencies; taken in by `include where assertions are written.
`ifndef CARTRIDGE_BANK_MAPPER_WITH_CHR_SPLIT_MACROS_SVH
`define CARTRIDGE_BANK_MAPPER_WITH_CHR_SPLIT_MACROS_SVH

// Checked on aclk, switched off while aresetn is low.
`define CBM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Checked on aclk at every edge, reset included.
`define CBM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

### sv/cbm_pkg.sv
// Package for the cartridge bank mapper: access codes, register indexes and item structs.
// No dependencies; used by the top level and its checker.
`default_nettype none

package cbm_pkg;

    typedef enum logic [1:0] {
        ACT_CPU_WRITE = 2'd0,
        ACT_CPU_READ  = 2'd1,
        ACT_PPU_READ  = 2'd2,
        ACT_PPU_WRITE = 2'd3
    } action_t;

    typedef struct packed {
        action_t     action;
        logic [11:0] address;
        logic [3:0]  ppu_bank;
        logic [7:0]  write_data;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       read_open_bus;
        logic [7:0] prg_bank;
        logic [3:0] chr_bank;
    } out_item_t;

    // bank register indexes, address bits 9..8 of a CPU write
    localparam logic [1:0] REG_PRG_LOW  = 2'd0;
    localparam logic [1:0] REG_FEEDBACK = 2'd1;
    localparam logic [1:0] REG_PRG_HIGH = 2'd2;
    localparam logic [1:0] REG_MODE     = 2'd3;

    // Value returned on a register read while the feedback bit is clear
    localparam logic [7:0] FEEDBACK_READ = 8'h04;

endpackage

`default_nettype wire

### sv/cartridge_bank_mapper_with_chr_split.sv
// Cartridge bank mapper with CHR split: bank registers, feedback bit, A13/A9 latch.
// Depends on cbm_pkg.
//
//  channel  | ports                          | direction | payload
//  ---------+--------------------------------+-----------+------------------------
//  input    | s_valid, s_ready, s_item       | in        | cbm_pkg::in_item_t
//  result   | m_valid, m_ready, m_item       | out       | cbm_pkg::out_item_t
//  config   | cfg_valid, cfg_ready, cfg_wdata| in        | prg_large (1 bit)
//
// One item per cycle sustained while m_ready is high; a result passes from the
// input register into the result register before it is on m_item. State is
// updated as an item moves from the input register into the result register, so
// items stay in order. When m_ready is low the result register holds; s_ready
// drops while both registers are full and m_ready is low.
// Reset clears all state at once; no clearing pass.
`default_nettype none

module cartridge_bank_mapper_with_chr_split (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire cbm_pkg::in_item_t  s_item,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output cbm_pkg::out_item_t      m_item,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_wdata
);

    // input register
    logic              in_vld_reg;
    cbm_pkg::in_item_t in_reg;
    // result register
    logic               out_vld_reg;
    cbm_pkg::out_item_t out_reg;
    cbm_pkg::out_item_t out_next;

    // mapper state
    logic [7:0] bank0_reg, bank1_reg, bank2_reg, bank3_reg;
    logic [7:0] bank0_next, bank1_next, bank2_next, bank3_next;
    logic       a9_reg, a9_next;
    logic       a13_reg, a13_next;
    logic       prg_large_reg;

    logic out_free;
    logic advance;

    logic [1:0] idx;
    logic       swap;
    logic [7:0] wdata;
    logic       a13;

    assign out_free  = !out_vld_reg || m_ready;
    assign advance   = in_vld_reg && out_free;
    assign s_ready   = !in_vld_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_vld_reg;
    assign m_item    = out_reg;

    always_comb begin
        bank0_next = bank0_reg;
        bank1_next = bank1_reg;
        bank2_next = bank2_reg;
        bank3_next = bank3_reg;
        a9_next    = a9_reg;
        a13_next   = a13_reg;
        out_next   = '0;

        idx   = in_reg.address[9:8];
        swap  = bank3_reg[0] &&
                ((idx inside {cbm_pkg::REG_PRG_LOW, cbm_pkg::REG_FEEDBACK}) ||
                 ((idx == cbm_pkg::REG_PRG_HIGH) && prg_large_reg));
        wdata = swap ? {in_reg.write_data[7:2], in_reg.write_data[0], in_reg.write_data[1]}
                     : in_reg.write_data;
        a13   = in_reg.ppu_bank[3];

        case (in_reg.action)
            cbm_pkg::ACT_CPU_WRITE: begin
                if (!in_reg.address[11]) begin
                    if (in_reg.address[0]) begin
                        // odd address: feedback bit toggles on D0 low while bank1 bit 0 is set
                        if (bank1_reg[0] && !wdata[0]) begin
                            bank1_next[2] = !bank1_reg[2];
                        end
                    end else begin
                        case (idx)
                            cbm_pkg::REG_PRG_LOW:  bank0_next = wdata;
                            cbm_pkg::REG_FEEDBACK: bank1_next = wdata;
                            cbm_pkg::REG_PRG_HIGH: bank2_next = wdata;
                            default:               bank3_next = wdata;
                        endcase
                    end
                end
            end
            cbm_pkg::ACT_CPU_READ: begin
                if (!in_reg.address[11]) begin
                    out_next.read_data = bank1_reg[2] ? 8'h00 : cbm_pkg::FEEDBACK_READ;
                end else begin
                    out_next.read_open_bus = 1'b1;
                end
            end
            default: begin
                // PPU access: latch A9 on rising A13
                if (!a13_reg && a13) begin
                    a9_next = in_reg.address[9];
                end
                a13_next = a13;
                if ((in_reg.action == cbm_pkg::ACT_PPU_READ) && bank0_reg[7] && !a13) begin
                    out_next.chr_bank = {1'b0, a9_next, in_reg.ppu_bank[1:0]};
                end else begin
                    out_next.chr_bank = in_reg.ppu_bank;
                end
            end
        endcase

        out_next.prg_bank = {bank2_next[3:0], bank0_next[3:0]} |
                            (bank3_next[2] ? 8'h00 : 8'h03);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg    <= 1'b0;
            out_vld_reg   <= 1'b0;
            bank0_reg     <= '0;
            bank1_reg     <= '0;
            bank2_reg     <= '0;
            bank3_reg     <= '0;
            a9_reg        <= 1'b0;
            a13_reg       <= 1'b0;
            prg_large_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (out_free) begin
                out_vld_reg <= in_vld_reg;
            end
            if (advance) begin
                bank0_reg <= bank0_next;
                bank1_reg <= bank1_next;
                bank2_reg <= bank2_next;
                bank3_reg <= bank3_next;
                a9_reg    <= a9_next;
                a13_reg   <= a13_next;
            end
            if (cfg_valid && cfg_ready) begin
                prg_large_reg <= cfg_wdata;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_item;
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

### sv/cbm_checker.sv
// Port-level checker for the cartridge bank mapper, bound to the top level.
// Depends on cbm_pkg and cartridge_bank_mapper_with_chr_split_macros.svh.
`default_nettype none

`include "cartridge_bank_mapper_with_chr_split_macros.svh"

module cbm_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire cbm_pkg::out_item_t m_item
);

    `CBM_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_item),
                "result item changed while stalled")
    `CBM_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid,
                       "result valid straight after reset")
    `CBM_ASSERT(a_ready_when_empty, !m_valid |-> s_ready,
                "input stalled with result side empty")
    `CBM_ASSERT(a_open_bus_zero,
                m_valid && m_item.read_open_bus |-> m_item.read_data == 8'h00,
                "open bus item carries read data")
    `CBM_ASSERT(a_read_value,
                m_valid && (m_item.read_data != 8'h00) |->
                    (m_item.read_data == cbm_pkg::FEEDBACK_READ) &&
                    (m_item.chr_bank == 4'h0) && !m_item.read_open_bus,
                "bad register read item")

endmodule

bind cartridge_bank_mapper_with_chr_split cbm_checker u_cbm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

`default_nettype wire
